// ===== rtl/tksd_pkg.sv =====
package tksd_pkg;

    localparam int MAX_EVENTS = 4;
    localparam int COUNT_W    = 3;
    localparam int INDEX_W    = 2;

    // Fixed characters of the escape sequences.
    localparam logic [7:0] CHR_ESC     = 8'd27;
    localparam logic [7:0] CHR_BRACKET = 8'h5B;
    localparam logic [7:0] CHR_O       = 8'h4F;
    localparam logic [7:0] CHR_TILDE   = 8'h7E;
    localparam logic [7:0] CHR_ARROW_LO = 8'd65;
    localparam logic [7:0] CHR_ARROW_HI = 8'd68;
    localparam logic [7:0] CHR_DIGIT_2 = 8'd50;
    localparam logic [7:0] CHR_DIGIT_3 = 8'd51;
    localparam logic [7:0] CHR_DIGIT_5 = 8'd53;
    localparam logic [7:0] CHR_DIGIT_6 = 8'd54;
    localparam logic [7:0] CHR_FKEY_LO = 8'd80;
    localparam logic [7:0] CHR_FKEY_HI = 8'd83;
    localparam logic [7:0] CHR_HOME    = 8'd72;
    localparam logic [7:0] CHR_END     = 8'd70;

    // Input kinds carried on s_tuser.
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    typedef enum logic [1:0] {
        REG_ESCAPE    = 2'd0,
        REG_ENTER     = 2'd1,
        REG_TAB       = 2'd2,
        REG_BACKSPACE = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [7:0] escape_key_code;
        logic [7:0] enter_key_code;
        logic [7:0] tab_key_code;
        logic [7:0] backspace_key_code;
    } cfg_t;

    typedef struct packed {
        logic [7:0] key_code;
        logic       special_key;
    } key_event_t;

    typedef struct packed {
        key_event_t [MAX_EVENTS-1:0] events;
        logic [COUNT_W-1:0]          count;
    } event_bundle_t;

endpackage

// ===== rtl/terminal_key_sequence_decoder.sv =====
// Terminal key sequence decoder. Received terminal bytes enter on the s_ stream
// (s_tuser low, byte in s_tdata) and come out on the m_ stream as key events:
// a key code in m_tdata and a special-key flag in m_tuser, with m_tlast marking
// the final event caused by one request. A request with s_tuser high is the
// silence timeout tick; it aborts a partial escape sequence. Recognized
// sequences are ESC [ A-D, ESC [ 2/3/5/6 ~ and ESC O P-S/H/F. An aborted
// sequence replays its prefix: the escape key as a special event with the
// configured escape code, then '[' or 'O' as plain bytes and any held digit
// via ground; the aborting byte is then decoded from ground. Enter, tab and
// backspace codes come from the APB registers at 0x0 (escape), 0x4 (enter),
// 0x8 (tab) and 0xC (backspace). A request yields zero to four events. The
// block takes a new request every cycle as long as each yields at most one
// event and m_tready stays high; a request with several events holds the single
// output port until its last one is taken, and that port sets the sustained
// rate. A request passes the input register, then the event buffer.
module terminal_key_sequence_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    // Byte / timeout requests.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // rx_byte[7:0]
    input  logic       s_tuser,    // opcode (0 byte, 1 timeout)
    // Key events.
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // key_code[7:0]
    output logic       m_tuser,    // special_key
    output logic       m_tlast,    // last_of_run
    // Configuration.
    input  logic       psel,
    input  logic       penable,
    input  logic       pwrite,
    input  logic [3:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);
    import tksd_pkg::*;

    cfg_t          cfg_reg;
    reg_index_t    reg_sel;
    logic          cfg_write;

    logic          in_valid_reg;
    logic          in_opcode_reg;
    logic [7:0]    in_byte_reg;

    event_bundle_t bundle;
    logic          buf_free;
    logic          advance;

    // The APB port always completes in its access cycle.
    assign pready    = 1'b1;
    assign reg_sel   = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.escape_key_code    <= CHR_ESC;
            cfg_reg.enter_key_code     <= 8'd13;
            cfg_reg.tab_key_code       <= 8'd9;
            cfg_reg.backspace_key_code <= 8'd8;
        end else if (cfg_write) begin
            unique case (reg_sel)
                REG_ESCAPE:    cfg_reg.escape_key_code    <= pwdata[7:0];
                REG_ENTER:     cfg_reg.enter_key_code     <= pwdata[7:0];
                REG_TAB:       cfg_reg.tab_key_code       <= pwdata[7:0];
                REG_BACKSPACE: cfg_reg.backspace_key_code <= pwdata[7:0];
                default:       cfg_reg.escape_key_code    <= cfg_reg.escape_key_code;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_ESCAPE:    prdata = {24'd0, cfg_reg.escape_key_code};
            REG_ENTER:     prdata = {24'd0, cfg_reg.enter_key_code};
            REG_TAB:       prdata = {24'd0, cfg_reg.tab_key_code};
            REG_BACKSPACE: prdata = {24'd0, cfg_reg.backspace_key_code};
            default:       prdata = '0;
        endcase
    end

    // The registered request moves on when its events fit in the event buffer.
    // A request without events needs no buffer space and leaves at once.
    assign advance  = in_valid_reg && ((bundle.count == '0) || buf_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_opcode_reg <= s_tuser;
            in_byte_reg   <= s_tdata;
        end
    end

    tksd_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .opcode  (in_opcode_reg),
        .rx_byte (in_byte_reg),
        .cfg     (cfg_reg),
        .bundle  (bundle)
    );

    tksd_event_buf u_event_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && (bundle.count != '0)),
        .bundle   (bundle),
        .free     (buf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/tksd_decode.sv =====
module tksd_decode (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  logic                   opcode,
    input  logic [7:0]             rx_byte,
    input  tksd_pkg::cfg_t         cfg,
    output tksd_pkg::event_bundle_t bundle
);
    import tksd_pkg::*;

    typedef enum logic [4:0] {
        ST_GROUND = 5'b00001,
        ST_ESC    = 5'b00010,
        ST_BR     = 5'b00100,
        ST_O      = 5'b01000,
        ST_TILDE  = 5'b10000
    } parse_state_t;

    parse_state_t state_reg, state_next;
    logic [7:0]   held_digit_reg, held_digit_next;

    // A byte decoded from ground: the configured control keys are special.
    function automatic key_event_t ground_event(input logic [7:0] c, input cfg_t r);
        key_event_t ev;
        ev.key_code    = c;
        ev.special_key = (c == r.enter_key_code) || (c == r.tab_key_code) ||
                         (c == r.backspace_key_code);
        return ev;
    endfunction

    logic is_arrow, is_digit, is_fkey;
    logic do_abort, do_ground;

    assign is_arrow = (rx_byte >= CHR_ARROW_LO) && (rx_byte <= CHR_ARROW_HI);
    assign is_digit = (rx_byte == CHR_DIGIT_2) || (rx_byte == CHR_DIGIT_3) ||
                      (rx_byte == CHR_DIGIT_5) || (rx_byte == CHR_DIGIT_6);
    assign is_fkey  = ((rx_byte >= CHR_FKEY_LO) && (rx_byte <= CHR_FKEY_HI)) ||
                      (rx_byte == CHR_HOME) || (rx_byte == CHR_END);

    always_comb begin
        state_next      = state_reg;
        held_digit_next = held_digit_reg;
        bundle          = '0;
        do_abort        = 1'b0;
        do_ground       = 1'b0;

        if (opcode == OP_TIMEOUT) begin
            do_abort = 1'b1;
        end else begin
            unique case (state_reg)
                ST_GROUND: begin
                    do_ground = 1'b1;
                end
                ST_ESC: begin
                    if (rx_byte == CHR_BRACKET) begin
                        state_next = ST_BR;
                    end else if (rx_byte == CHR_O) begin
                        state_next = ST_O;
                    end else begin
                        do_abort  = 1'b1;
                        do_ground = 1'b1;
                    end
                end
                ST_BR: begin
                    if (is_arrow) begin
                        bundle.events[0] = '{key_code: rx_byte, special_key: 1'b1};
                        bundle.count     = COUNT_W'(1);
                        state_next       = ST_GROUND;
                    end else if (is_digit) begin
                        held_digit_next = rx_byte;
                        state_next      = ST_TILDE;
                    end else begin
                        do_abort  = 1'b1;
                        do_ground = 1'b1;
                    end
                end
                ST_O: begin
                    if (is_fkey) begin
                        bundle.events[0] = '{key_code: rx_byte, special_key: 1'b1};
                        bundle.count     = COUNT_W'(1);
                        state_next       = ST_GROUND;
                    end else begin
                        do_abort  = 1'b1;
                        do_ground = 1'b1;
                    end
                end
                ST_TILDE: begin
                    if (rx_byte == CHR_TILDE) begin
                        bundle.events[0] = '{key_code: held_digit_reg, special_key: 1'b1};
                        bundle.count     = COUNT_W'(1);
                        state_next       = ST_GROUND;
                    end else begin
                        do_abort  = 1'b1;
                        do_ground = 1'b1;
                    end
                end
                default: begin
                    do_ground = 1'b1;
                end
            endcase
        end

        // Replay of the pending prefix; the held digit goes back through ground.
        if (do_abort) begin
            state_next = ST_GROUND;
            unique case (state_reg)
                ST_ESC: begin
                    bundle.events[0] = '{key_code: cfg.escape_key_code, special_key: 1'b1};
                    bundle.count     = COUNT_W'(1);
                end
                ST_BR: begin
                    bundle.events[0] = '{key_code: cfg.escape_key_code, special_key: 1'b1};
                    bundle.events[1] = '{key_code: CHR_BRACKET, special_key: 1'b0};
                    bundle.count     = COUNT_W'(2);
                end
                ST_O: begin
                    bundle.events[0] = '{key_code: cfg.escape_key_code, special_key: 1'b1};
                    bundle.events[1] = '{key_code: CHR_O, special_key: 1'b0};
                    bundle.count     = COUNT_W'(2);
                end
                ST_TILDE: begin
                    bundle.events[0] = '{key_code: cfg.escape_key_code, special_key: 1'b1};
                    bundle.events[1] = '{key_code: CHR_BRACKET, special_key: 1'b0};
                    bundle.events[2] = ground_event(held_digit_reg, cfg);
                    bundle.count     = COUNT_W'(3);
                end
                default: begin
                    bundle.count = '0;
                end
            endcase
        end

        // The received byte itself, decoded from ground after any replay.
        if (do_ground) begin
            if (rx_byte == CHR_ESC) begin
                state_next = ST_ESC;
            end else begin
                bundle.events[bundle.count[INDEX_W-1:0]] = ground_event(rx_byte, cfg);
                bundle.count = bundle.count + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_GROUND;
            held_digit_reg <= '0;
        end else if (advance) begin
            state_reg      <= state_next;
            held_digit_reg <= held_digit_next;
        end
    end

endmodule

// ===== rtl/tksd_event_buf.sv =====
module tksd_event_buf (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    load,
    input  tksd_pkg::event_bundle_t bundle,
    output logic                    free,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [7:0]              m_tdata,   // key_code[7:0]
    output logic                    m_tuser,   // special_key
    output logic                    m_tlast
);
    import tksd_pkg::*;

    logic                        valid_reg, valid_next;
    logic [INDEX_W-1:0]          idx_reg, idx_next;
    logic [COUNT_W-1:0]          count_reg, count_next;
    key_event_t [MAX_EVENTS-1:0] events_reg, events_next;
    logic                        is_last, pop;

    assign is_last  = ({1'b0, idx_reg} + COUNT_W'(1)) == count_reg;
    assign pop      = valid_reg && m_tready;
    assign free     = !valid_reg || (pop && is_last);

    assign m_tvalid = valid_reg;
    assign m_tdata  = events_reg[idx_reg].key_code;
    assign m_tuser  = events_reg[idx_reg].special_key;
    assign m_tlast  = is_last;

    always_comb begin
        valid_next  = valid_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        events_next = events_reg;
        if (load) begin
            valid_next  = 1'b1;
            idx_next    = '0;
            count_next  = bundle.count;
            events_next = bundle.events;
        end else if (pop) begin
            if (is_last) begin
                valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + INDEX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
            count_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
        end
        events_reg <= events_next;
    end

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (count_reg != '0))
        else $error("event buffer holds an empty bundle");

    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> ({1'b0, idx_reg} < count_reg))
        else $error("event index past bundle count");

    a_drains_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && is_last && !load) |=> !valid_reg)
        else $error("event buffer still valid after last event taken");

    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> free)
        else $error("bundle loaded over pending events");

endmodule

// ===== verif/terminal_key_sequence_decoder_tb.sv =====
module terminal_key_sequence_decoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tksd_pkg::*;

    // Parser states of the predictor. The block keeps its own encoding inside,
    // so these only need to track the same sequence positions.
    typedef enum logic [2:0] {
        PS_GROUND,
        PS_ESC,
        PS_BRACKET,
        PS_SS3,
        PS_TILDE
    } parse_state_t;

    // One request as it travels on the s_ stream.
    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } key_request_t;

    // One key event as it should appear on the m_ stream.
    typedef struct packed {
        logic [7:0] key_code;
        logic       special_key;
        logic       last_of_run;
    } key_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;    // rx_byte[7:0]
    logic        s_tuser = 1'b0;    // opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // key_code[7:0]
    logic        m_tuser;           // special_key
    logic        m_tlast;           // last_of_run
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    terminal_key_sequence_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 aclk = ~aclk;

    // Predictor state: a private copy of the key code registers and of the
    // parser position, advanced once per accepted request.
    cfg_t         key_cfg;
    parse_state_t parse_state;
    logic [7:0]   held_digit;
    key_result_t  run_keys[$];       // events of the request being decoded
    key_result_t  expected_keys[$];  // events still owed by the block

    key_request_t pending_requests[$];
    int           requests_queued = 0;
    int           requests_accepted = 0;
    int           mismatch_count = 0;

    // Handshake bookkeeping, written at the rising edge and read by the
    // falling-edge drivers so that neither side races the other.
    logic         s_taken = 1'b0;
    logic         m_taken = 1'b0;
    bit           s_steady = 1'b0;
    bit           m_steady = 1'b0;
    int           s_gap_left = 0;
    int           m_stall_left = 0;

    // A single request never yields more than four events; anything past that
    // is dropped, since the block's event buffer holds only four.
    function automatic void push_key(logic [7:0] code, logic special);
        key_result_t k;
        if (run_keys.size() < MAX_EVENTS) begin
            k.key_code    = code;
            k.special_key = special;
            k.last_of_run = 1'b0;
            run_keys.push_back(k);
        end
    endfunction

    // Ground handling. ESC always opens a sequence, even when a key code
    // register also holds 27. A byte that matches several registers is still
    // reported once.
    function automatic void decode_from_ground(logic [7:0] c);
        if (c == CHR_ESC) begin
            parse_state = PS_ESC;
        end else begin
            push_key(c, c == key_cfg.enter_key_code || c == key_cfg.tab_key_code ||
                        c == key_cfg.backspace_key_code);
        end
    endfunction

    // Replay the prefix of a broken sequence. The parser goes back to ground
    // first, so the held digit is decoded as a fresh ground byte and can turn
    // special when a register equals it.
    function automatic void abandon_sequence();
        parse_state_t was;
        was = parse_state;
        parse_state = PS_GROUND;
        case (was)
            PS_ESC: begin
                push_key(key_cfg.escape_key_code, 1'b1);
            end
            PS_BRACKET: begin
                push_key(key_cfg.escape_key_code, 1'b1);
                push_key(CHR_BRACKET, 1'b0);
            end
            PS_SS3: begin
                push_key(key_cfg.escape_key_code, 1'b1);
                push_key(CHR_O, 1'b0);
            end
            PS_TILDE: begin
                push_key(key_cfg.escape_key_code, 1'b1);
                push_key(CHR_BRACKET, 1'b0);
                decode_from_ground(held_digit);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void decode_key_byte(logic [7:0] c);
        logic consumed;
        consumed = 1'b0;
        case (parse_state)
            PS_ESC: begin
                if (c == CHR_BRACKET) begin
                    parse_state = PS_BRACKET;
                    consumed = 1'b1;
                end else if (c == CHR_O) begin
                    parse_state = PS_SS3;
                    consumed = 1'b1;
                end
            end
            PS_BRACKET: begin
                if (c >= CHR_ARROW_LO && c <= CHR_ARROW_HI) begin
                    push_key(c, 1'b1);
                    parse_state = PS_GROUND;
                    consumed = 1'b1;
                end else if (c == CHR_DIGIT_2 || c == CHR_DIGIT_3 ||
                             c == CHR_DIGIT_5 || c == CHR_DIGIT_6) begin
                    held_digit = c;
                    parse_state = PS_TILDE;
                    consumed = 1'b1;
                end
            end
            PS_SS3: begin
                if ((c >= CHR_FKEY_LO && c <= CHR_FKEY_HI) || c == CHR_HOME ||
                    c == CHR_END) begin
                    push_key(c, 1'b1);
                    parse_state = PS_GROUND;
                    consumed = 1'b1;
                end
            end
            PS_TILDE: begin
                if (c == CHR_TILDE) begin
                    push_key(held_digit, 1'b1);
                    parse_state = PS_GROUND;
                    consumed = 1'b1;
                end
            end
            default: begin
                parse_state = PS_GROUND;
                decode_from_ground(c);
                consumed = 1'b1;
            end
        endcase
        // An unexpected byte breaks the sequence and is then decoded again
        // from ground.
        if (!consumed) begin
            abandon_sequence();
            decode_from_ground(c);
        end
    endfunction

    // Work out the key events of one accepted request and queue them, with
    // the last one of the run flagged.
    function automatic void decode_request(logic opcode, logic [7:0] rx_byte);
        key_result_t k;
        run_keys.delete();
        if (opcode == OP_TIMEOUT) begin
            abandon_sequence();
        end else begin
            decode_key_byte(rx_byte);
        end
        foreach (run_keys[i]) begin
            k = run_keys[i];
            k.last_of_run = (i == run_keys.size() - 1);
            expected_keys.push_back(k);
        end
    endfunction

    // Request driver. A request stays on the bus until it is taken; after
    // that the driver waits its drawn gap before offering the next one. Now
    // and then it switches between random gaps and back-to-back requests.
    always @(negedge aclk) begin : drive_requests
        key_request_t req;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_taken) begin
            // Still waiting for the block to take the current request.
        end else if (s_gap_left > 0) begin
            s_tvalid <= 1'b0;
            s_gap_left--;
        end else if (pending_requests.size() > 0) begin
            req = pending_requests.pop_front();
            s_tvalid <= 1'b1;
            s_tuser  <= req.opcode;
            s_tdata  <= req.rx_byte;
            if ($urandom_range(0, 11) == 0) begin
                s_steady = !s_steady;
            end
            s_gap_left = s_steady ? 0 : $urandom_range(0, 15);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Key event receiver. After every event taken it draws a random stall,
    // with stretches where it never stalls at all.
    always @(negedge aclk) begin : accept_keys
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_taken) begin
                if ($urandom_range(0, 11) == 0) begin
                    m_steady = !m_steady;
                end
                m_stall_left = m_steady ? 0 : $urandom_range(0, 15);
            end
            if (m_stall_left > 0) begin
                m_tready <= 1'b0;
                m_stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Both streams are observed at the rising edge. An accepted request feeds
    // the predictor; an accepted event is checked against the oldest event
    // still owed.
    always @(posedge aclk) begin : watch_streams
        key_result_t want;
        if (!aresetn) begin
            s_taken <= 1'b0;
            m_taken <= 1'b0;
        end else begin
            s_taken <= s_tvalid && s_tready;
            m_taken <= m_tvalid && m_tready;
            if (s_tvalid && s_tready) begin
                decode_request(s_tuser, s_tdata);
                requests_accepted++;
            end
            if (m_tvalid && m_tready) begin
                if (expected_keys.size() == 0) begin
                    $error("unexpected key event: key_code %0d special_key %0b last_of_run %0b",
                           m_tdata, m_tuser, m_tlast);
                    mismatch_count++;
                end else begin
                    want = expected_keys.pop_front();
                    if (m_tdata !== want.key_code) begin
                        $error("key_code: expected %0d, got %0d", want.key_code, m_tdata);
                        mismatch_count++;
                    end
                    if (m_tuser !== want.special_key) begin
                        $error("special_key: expected %0b, got %0b", want.special_key, m_tuser);
                        mismatch_count++;
                    end
                    if (m_tlast !== want.last_of_run) begin
                        $error("last_of_run: expected %0b, got %0b", want.last_of_run, m_tlast);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    task automatic queue_byte(logic [7:0] b);
        key_request_t req;
        req.opcode  = OP_BYTE;
        req.rx_byte = b;
        pending_requests.push_back(req);
        requests_queued++;
    endtask

    // The byte field of a timeout tick carries noise; the block must ignore it.
    task automatic queue_timeout();
        key_request_t req;
        req.opcode  = OP_TIMEOUT;
        req.rx_byte = 8'($urandom_range(0, 255));
        pending_requests.push_back(req);
        requests_queued++;
    endtask

    function automatic logic [7:0] pick_digit();
        case ($urandom_range(0, 3))
            0: return CHR_DIGIT_2;
            1: return CHR_DIGIT_3;
            2: return CHR_DIGIT_5;
            default: return CHR_DIGIT_6;
        endcase
    endfunction

    function automatic logic [7:0] pick_ss3_final();
        int r;
        r = $urandom_range(0, 5);
        if (r < 4) begin
            return CHR_FKEY_LO + 8'(r);
        end
        return (r == 4) ? CHR_HOME : CHR_END;
    endfunction

    // Start of a sequence, cut after one, two or three bytes.
    task automatic queue_prefix(int depth);
        queue_byte(CHR_ESC);
        if (depth == 3) begin
            queue_byte(CHR_BRACKET);
            queue_byte(pick_digit());
        end else if (depth == 2) begin
            queue_byte($urandom_range(0, 1) ? CHR_BRACKET : CHR_O);
        end
    endtask

    // Mostly complete sequences with random finals, mixed with broken ones,
    // stray bytes and timeout ticks.
    task automatic queue_random_traffic(int count);
        int target;
        target = requests_queued + count;
        while (requests_queued < target) begin
            case ($urandom_range(0, 11))
                0, 1: queue_byte(8'($urandom_range(0, 255)));
                2: begin
                    queue_byte(CHR_ESC);
                    queue_byte(CHR_BRACKET);
                    queue_byte(CHR_ARROW_LO + 8'($urandom_range(0, 3)));
                end
                3: begin
                    queue_byte(CHR_ESC);
                    queue_byte(CHR_BRACKET);
                    queue_byte(pick_digit());
                    queue_byte(CHR_TILDE);
                end
                4: begin
                    queue_byte(CHR_ESC);
                    queue_byte(CHR_O);
                    queue_byte(pick_ss3_final());
                end
                5, 6: begin
                    queue_prefix($urandom_range(1, 3));
                    queue_timeout();
                end
                7, 8: begin
                    queue_prefix($urandom_range(1, 3));
                    queue_byte(8'($urandom_range(0, 255)));
                end
                9: queue_timeout();
                10: begin
                    // A second ESC breaks the sequence and opens a new one.
                    queue_prefix($urandom_range(1, 3));
                    queue_byte(CHR_ESC);
                end
                default: begin
                    // Near misses: bytes close to the sequence characters.
                    queue_prefix($urandom_range(1, 3));
                    queue_byte(8'($urandom_range(48, 126)));
                end
            endcase
        end
    endtask

    // Register write: setup cycle, then access cycle until pready. The
    // predictor takes the new value once the write is through.
    task automatic write_register(reg_index_t idx, logic [7:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ESCAPE:    key_cfg.escape_key_code    = value;
            REG_ENTER:     key_cfg.enter_key_code     = value;
            REG_TAB:       key_cfg.tab_key_code       = value;
            REG_BACKSPACE: key_cfg.backspace_key_code = value;
            default: begin
            end
        endcase
    endtask

    task automatic write_all_registers(logic [7:0] esc_code, logic [7:0] enter_code,
                                       logic [7:0] tab_code, logic [7:0] bs_code);
        write_register(REG_ESCAPE, esc_code);
        write_register(REG_ENTER, enter_code);
        write_register(REG_TAB, tab_code);
        write_register(REG_BACKSPACE, bs_code);
    endtask

    // Wait until every queued request has been taken and every owed event
    // has come out, then let the clock run on before returning, since a request
    // that yields no event may still be in flight. Requests never taken and
    // events that never arrive within the limit count as failures.
    task automatic wait_for_keys(int limit);
        int waited;
        waited = 0;
        while ((requests_accepted != requests_queued || expected_keys.size() != 0) &&
               waited < limit) begin
            @(negedge aclk);
            waited++;
        end
        if (requests_accepted != requests_queued) begin
            $error("%0d requests never taken", requests_queued - requests_accepted);
            mismatch_count++;
        end
        if (expected_keys.size() != 0) begin
            $error("%0d key events never arrived", expected_keys.size());
            mismatch_count++;
            expected_keys.delete();
        end
        repeat (8) @(negedge aclk);
    endtask

    initial begin
        key_cfg.escape_key_code    = CHR_ESC;
        key_cfg.enter_key_code     = 8'd13;
        key_cfg.tab_key_code       = 8'd9;
        key_cfg.backspace_key_code = 8'd8;
        parse_state = PS_GROUND;
        held_digit  = 8'd0;

        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        // Reset register values. Plain extremes, the three special ground
        // keys, one of each sequence family, and the aborts: a timeout in
        // ground, a lone ESC timing out, and a held digit broken by a letter,
        // which yields the full four events.
        queue_byte(8'd0);
        queue_byte(8'd255);
        queue_byte(8'd13);
        queue_byte(8'd9);
        queue_byte(8'd8);
        queue_byte(CHR_ESC);
        queue_byte(CHR_BRACKET);
        queue_byte(CHR_ARROW_LO);
        queue_byte(CHR_ESC);
        queue_byte(CHR_O);
        queue_byte(CHR_FKEY_LO);
        queue_byte(CHR_ESC);
        queue_byte(CHR_BRACKET);
        queue_byte(CHR_DIGIT_5);
        queue_byte(CHR_TILDE);
        queue_timeout();
        queue_byte(CHR_ESC);
        queue_timeout();
        queue_byte(CHR_ESC);
        queue_byte(CHR_BRACKET);
        queue_byte(CHR_DIGIT_3);
        queue_byte(8'h5A);
        queue_random_traffic(40);
        wait_for_keys(50000);

        // Register extremes with enter and tab both at 255, so one byte
        // matches two registers, and backspace equal to a digit, so the
        // replayed digit turns special.
        write_all_registers(8'd0, 8'd255, 8'd255, CHR_DIGIT_3);
        queue_byte(8'd255);
        queue_byte(CHR_ESC);
        queue_byte(CHR_BRACKET);
        queue_byte(CHR_DIGIT_3);
        queue_timeout();
        queue_random_traffic(25);
        wait_for_keys(50000);

        // Enter equal to ESC: the byte must still open a sequence. Backspace
        // equal to '[' must not change how the bracket is replayed.
        write_all_registers(8'd255, CHR_ESC, 8'd0, CHR_BRACKET);
        queue_byte(CHR_ESC);
        queue_timeout();
        queue_byte(CHR_ESC);
        queue_byte(CHR_BRACKET);
        queue_timeout();
        queue_random_traffic(25);
        wait_for_keys(50000);

        // Random register values.
        write_all_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        queue_random_traffic(25);
        wait_for_keys(50000);

        if (mismatch_count == 0) begin
            $display("terminal_key_sequence_decoder_tb: done, clean");
        end else begin
            $display("terminal_key_sequence_decoder_tb: done, errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial begin
        #5_000_000;
        $display("terminal_key_sequence_decoder_tb: done, errors");
        $finish;
    end

endmodule
